FILE: rtl/bdq_pkg.sv
// shared types and constants of the bounded deque
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 4;
  localparam int OCC_W   = 5;
  localparam int LI_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK     = 3'd0,
    CMD_POP_BACK      = 3'd1,
    CMD_SHIFT_FRONT   = 3'd2,
    CMD_UNSHIFT_FRONT = 3'd3,
    CMD_REMOVE        = 3'd4,
    CMD_GET           = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_RANGE     = 3'd4
  } status_e;

  // logical index used for a store read
  typedef enum logic [2:0] {
    LI_BACK,
    LI_FRONT,
    LI_POS,
    LI_IDX,
    LI_IDX_NEXT
  } li_sel_e;

  // slot and data for a store write
  typedef enum logic [1:0] {
    WR_BACK,
    WR_FRONT,
    WR_MOVE
  } wr_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_MOVE_RD,
    S_MOVE_WR,
    S_OUT
  } state_e;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    li_sel_e li_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    head_inc;
    logic    head_dec;
    logic    idx_clr;
    logic    idx_inc;
    logic    res_set;
    status_e res_status;
    logic    res_from_rd;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e op;
    logic empty;
    logic full;
    logic pos_oob;
    logic match;
    logic idx_last;
    logic move_last;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: rtl/bdq_dpath.sv
// deque datapath: ring store, pointers, count, result and output registers
`timescale 1ns / 1ps

module bdq_dpath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bdq_pkg::dp_cmd_t          cmd_i,
  output bdq_pkg::dp_stat_t         stat_o,
  input  logic [2:0]                in_command_i,
  input  logic [31:0]               in_value_i,
  input  logic [bdq_pkg::POS_W-1:0] in_position_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [31:0]               out_data_o,
  output logic [2:0]                out_status_o,
  output logic [bdq_pkg::OCC_W-1:0] out_occupancy_o
);

  localparam int AW = bdq_pkg::ADDR_W;
  localparam int CW = bdq_pkg::CNT_W;

  logic [bdq_pkg::DATA_W-1:0] mem_q [bdq_pkg::DEPTH];
  logic [bdq_pkg::DATA_W-1:0] rdata_q;

  bdq_pkg::cmd_e              op_q;
  logic [bdq_pkg::DATA_W-1:0] val_q;
  logic [bdq_pkg::POS_W-1:0]  pos_q;
  logic [AW-1:0]              head_q, head_d;
  logic [CW-1:0]              count_q, count_d;
  logic [AW-1:0]              idx_q, idx_d;
  bdq_pkg::status_e           res_status_q;
  logic [bdq_pkg::DATA_W-1:0] res_data_q;
  logic                       out_valid_q;
  logic [31:0]                out_data_q;
  logic [2:0]                 out_status_q;
  logic [bdq_pkg::OCC_W-1:0]  out_occ_q;

  logic [AW-1:0]              li, raddr, waddr, head_prev;
  logic [bdq_pkg::DATA_W-1:0] wdata;
  logic [CW:0]                idx_p1, idx_p2;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [AW-1:0] lidx);
    logic [AW:0] sum;
    sum = {1'b0, head} + {1'b0, lidx};
    if (sum >= (AW+1)'(bdq_pkg::DEPTH)) begin
      sum = sum - (AW+1)'(bdq_pkg::DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign head_prev = (head_q == '0) ? AW'(bdq_pkg::DEPTH - 1) : head_q - AW'(1);
  assign idx_p1    = (CW+1)'(idx_q) + (CW+1)'(1);
  assign idx_p2    = (CW+1)'(idx_q) + (CW+1)'(2);

  // read address
  always_comb begin
    case (cmd_i.li_sel)
      bdq_pkg::LI_BACK:     li = AW'(count_q - CW'(1));
      bdq_pkg::LI_FRONT:    li = '0;
      bdq_pkg::LI_POS:      li = AW'(bdq_pkg::LI_W'(pos_q));
      bdq_pkg::LI_IDX:      li = idx_q;
      bdq_pkg::LI_IDX_NEXT: li = AW'(idx_p1);
      default:              li = '0;
    endcase
  end
  assign raddr = slot_of(head_q, li);

  // write address and data
  always_comb begin
    case (cmd_i.wr_sel)
      bdq_pkg::WR_BACK: begin
        waddr = slot_of(head_q, AW'(count_q));
        wdata = val_q;
      end
      bdq_pkg::WR_FRONT: begin
        waddr = head_prev;
        wdata = val_q;
      end
      bdq_pkg::WR_MOVE: begin
        waddr = slot_of(head_q, idx_q);
        wdata = rdata_q;
      end
      default: begin
        waddr = '0;
        wdata = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    head_d = head_q;
    if (cmd_i.head_inc) begin
      head_d = slot_of(head_q, AW'(1));
    end else if (cmd_i.head_dec) begin
      head_d = head_prev;
    end
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = AW'(idx_p1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= bdq_pkg::cmd_e'(in_command_i);
      val_q <= bdq_pkg::DATA_W'(in_value_i);
      pos_q <= in_position_i;
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_data_q   <= cmd_i.res_from_rd ? rdata_q : '0;
    end
    if (cmd_i.out_load) begin
      out_data_q   <= 32'(res_data_q);
      out_status_q <= res_status_q;
      out_occ_q    <= bdq_pkg::OCC_W'(count_q);
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.full      = (count_q >= CW'(bdq_pkg::DEPTH));
  assign stat_o.pos_oob   = (bdq_pkg::LI_W'(pos_q) >= bdq_pkg::LI_W'(count_q));
  assign stat_o.match     = (rdata_q == val_q);
  assign stat_o.idx_last  = (idx_p1 >= (CW+1)'(count_q));
  assign stat_o.move_last = (idx_p2 >= (CW+1)'(count_q));
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign out_status_o    = out_status_q;
  assign out_occupancy_o = out_occ_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(bdq_pkg::DEPTH))
    else $error("entry count above depth");

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_en && cmd_i.cnt_inc) |-> (count_q < CW'(bdq_pkg::DEPTH)))
    else $error("write into a full queue");

  a_dec_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> (count_q != '0) && !cmd_i.cnt_inc)
    else $error("count decrement on empty queue");

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten before transfer");
`endif

endmodule

FILE: rtl/bdq_ctrl.sv
// deque controller state machine
`timescale 1ns / 1ps

module bdq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bdq_pkg::dp_stat_t  stat_i,
  output bdq_pkg::dp_cmd_t   cmd_o
);

  bdq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bdq_pkg::S_IDLE: begin
        if (in_valid_i) state_d = bdq_pkg::S_DECODE;
      end
      bdq_pkg::S_DECODE: begin
        case (stat_i.op)
          bdq_pkg::CMD_POP_BACK,
          bdq_pkg::CMD_SHIFT_FRONT: begin
            state_d = stat_i.empty ? bdq_pkg::S_OUT : bdq_pkg::S_READ;
          end
          bdq_pkg::CMD_GET: begin
            state_d = stat_i.pos_oob ? bdq_pkg::S_OUT : bdq_pkg::S_READ;
          end
          bdq_pkg::CMD_REMOVE: begin
            state_d = stat_i.empty ? bdq_pkg::S_OUT : bdq_pkg::S_SCAN_RD;
          end
          default: state_d = bdq_pkg::S_OUT;
        endcase
      end
      bdq_pkg::S_READ:    state_d = bdq_pkg::S_OUT;
      bdq_pkg::S_SCAN_RD: state_d = bdq_pkg::S_SCAN_CMP;
      bdq_pkg::S_SCAN_CMP: begin
        if (stat_i.idx_last) begin
          state_d = bdq_pkg::S_OUT;
        end else if (stat_i.match) begin
          state_d = bdq_pkg::S_MOVE_RD;
        end else begin
          state_d = bdq_pkg::S_SCAN_RD;
        end
      end
      bdq_pkg::S_MOVE_RD: state_d = bdq_pkg::S_MOVE_WR;
      bdq_pkg::S_MOVE_WR: begin
        state_d = stat_i.move_last ? bdq_pkg::S_OUT : bdq_pkg::S_MOVE_RD;
      end
      bdq_pkg::S_OUT: begin
        if (!stat_i.out_busy) state_d = bdq_pkg::S_IDLE;
      end
      default: state_d = bdq_pkg::S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.li_sel     = bdq_pkg::LI_FRONT;
    cmd_o.wr_sel     = bdq_pkg::WR_BACK;
    cmd_o.res_status = bdq_pkg::ST_OK;
    in_ready_o       = 1'b0;
    case (state_q)
      bdq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      bdq_pkg::S_DECODE: begin
        case (stat_i.op)
          bdq_pkg::CMD_PUSH_BACK: begin
            cmd_o.res_set = 1'b1;
            if (stat_i.full) begin
              cmd_o.res_status = bdq_pkg::ST_FULL;
            end else begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_sel  = bdq_pkg::WR_BACK;
              cmd_o.cnt_inc = 1'b1;
            end
          end
          bdq_pkg::CMD_UNSHIFT_FRONT: begin
            cmd_o.res_set = 1'b1;
            if (stat_i.full) begin
              cmd_o.res_status = bdq_pkg::ST_FULL;
            end else begin
              cmd_o.wr_en    = 1'b1;
              cmd_o.wr_sel   = bdq_pkg::WR_FRONT;
              cmd_o.head_dec = 1'b1;
              cmd_o.cnt_inc  = 1'b1;
            end
          end
          bdq_pkg::CMD_POP_BACK: begin
            if (stat_i.empty) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = bdq_pkg::ST_EMPTY;
            end else begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.li_sel  = bdq_pkg::LI_BACK;
              cmd_o.cnt_dec = 1'b1;
            end
          end
          bdq_pkg::CMD_SHIFT_FRONT: begin
            if (stat_i.empty) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = bdq_pkg::ST_EMPTY;
            end else begin
              cmd_o.rd_en    = 1'b1;
              cmd_o.li_sel   = bdq_pkg::LI_FRONT;
              cmd_o.head_inc = 1'b1;
              cmd_o.cnt_dec  = 1'b1;
            end
          end
          bdq_pkg::CMD_GET: begin
            if (stat_i.pos_oob) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = bdq_pkg::ST_RANGE;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.li_sel = bdq_pkg::LI_POS;
            end
          end
          bdq_pkg::CMD_REMOVE: begin
            if (stat_i.empty) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = bdq_pkg::ST_NOT_FOUND;
            end else begin
              cmd_o.idx_clr = 1'b1;
            end
          end
          default: begin
            cmd_o.res_set = 1'b1;
          end
        endcase
      end
      bdq_pkg::S_READ: begin
        cmd_o.res_set     = 1'b1;
        cmd_o.res_from_rd = 1'b1;
      end
      bdq_pkg::S_SCAN_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.li_sel = bdq_pkg::LI_IDX;
      end
      bdq_pkg::S_SCAN_CMP: begin
        if (stat_i.match) begin
          cmd_o.res_set     = 1'b1;
          cmd_o.res_from_rd = 1'b1;
          cmd_o.cnt_dec     = stat_i.idx_last;
        end else if (stat_i.idx_last) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = bdq_pkg::ST_NOT_FOUND;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      bdq_pkg::S_MOVE_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.li_sel = bdq_pkg::LI_IDX_NEXT;
      end
      bdq_pkg::S_MOVE_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = bdq_pkg::WR_MOVE;
        cmd_o.idx_inc = 1'b1;
        cmd_o.cnt_dec = stat_i.move_last;
      end
      bdq_pkg::S_OUT: begin
        cmd_o.out_load = !stat_i.out_busy;
      end
      default: begin
        cmd_o.load = 1'b0;
      end
    endcase
  end

`ifndef SYNTH
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd_o.wr_en && !cmd_o.rd_en && !cmd_o.out_load)
    else $error("transfer accepted while a command is at work");

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == bdq_pkg::S_DECODE))
    else $error("accepted command not decoded");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (state_q == bdq_pkg::S_IDLE))
    else $error("result loaded without return to idle");
`endif

endmodule

FILE: rtl/bounded_deque_with_remove.sv
// top level of the bounded double-ended queue with remove by value
// sequence: push, unshift and commands that fail at decode go from decode to output;
//   pop, shift and get pass a read state between, set by the registered store read port
// remove: a read and a compare state per entry scanned up to the match, then a read
//   and a write state per entry moved to close the gap, as both share the one read port
// throughput: one command at a time; the output state waits until the last result is taken,
//   and the next input transfer is taken the cycle after the result enters the output register
// reset: asynchronous active low; queue empty, head at slot zero, store contents undefined
`timescale 1ns / 1ps

module bounded_deque_with_remove (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // value [31:0], position [35:32], zero pad [39:36]
  input  logic [2:0]  s_axis_tuser_i,   // command [2:0]
  // result channel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // data_out [31:0], occupancy [36:32], zero pad [39:37]
  output logic [2:0]  m_axis_tuser_o    // status [2:0]
);

  bdq_pkg::dp_cmd_t  dp_cmd;
  bdq_pkg::dp_stat_t dp_stat;

  logic [31:0]               res_data;
  logic [bdq_pkg::OCC_W-1:0] res_occ;

  // sequencing of each command, one transfer in flight
  bdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // ring store, pointers and output register
  bdq_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .stat_o          (dp_stat),
    .in_command_i    (s_axis_tuser_i),
    .in_value_i      (s_axis_tdata_i[31:0]),
    .in_position_i   (s_axis_tdata_i[35:32]),
    .out_ready_i     (m_axis_tready_i),
    .out_valid_o     (m_axis_tvalid_o),
    .out_data_o      (res_data),
    .out_status_o    (m_axis_tuser_o),
    .out_occupancy_o (res_occ)
  );

  // pack the result fields, lowest field first
  assign m_axis_tdata_o = {3'b000, res_occ, res_data};

endmodule

FILE: bench/tb_bounded_deque_with_remove.sv
// self-checking testbench of the bounded double-ended queue with remove by value
`timescale 1ns / 1ps

module tb_bounded_deque_with_remove;

  // command codes the block has no meaning for, it answers them with ok and no change
  localparam logic [2:0] CMD_UNUSED_A = 3'd6;
  localparam logic [2:0] CMD_UNUSED_B = 3'd7;

  localparam int STALL_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int SETTLE_CYCLES = 80;  // margin for the longest command, a remove
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [bdq_pkg::DATA_W-1:0] data;
    bdq_pkg::status_e           status;
    logic [bdq_pkg::OCC_W-1:0]  occ;
  } deque_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;   // value [31:0], position [35:32], zero pad [39:36]
  logic [2:0]  s_axis_tuser_i = '0;   // command [2:0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;        // data_out [31:0], occupancy [36:32], zero pad [39:37]
  logic [2:0]  m_axis_tuser_o;        // status [2:0]

  bounded_deque_with_remove u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // shadow copy of the deque
  logic [bdq_pkg::DATA_W-1:0] ring [bdq_pkg::DEPTH];
  logic [bdq_pkg::ADDR_W-1:0] front_slot = '0;
  logic [bdq_pkg::OCC_W-1:0]  held = '0;

  deque_result_t pending_results[$];
  int error_count = 0;
  int quiet_cycles = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;

  function automatic logic [bdq_pkg::ADDR_W-1:0] ring_slot(input int idx);
    return bdq_pkg::ADDR_W'((int'(front_slot) + idx) % bdq_pkg::DEPTH);
  endfunction

  // update the shadow deque with one command and queue the result it must give
  task automatic apply_command(input logic [2:0] cmd, input logic [bdq_pkg::DATA_W-1:0] val,
                               input logic [bdq_pkg::POS_W-1:0] pos);
    deque_result_t res;
    int hit;
    res.data = '0;
    res.status = bdq_pkg::ST_OK;
    hit = -1;
    case (cmd)
      bdq_pkg::CMD_PUSH_BACK: begin
        if (int'(held) == bdq_pkg::DEPTH) res.status = bdq_pkg::ST_FULL;
        else begin
          ring[ring_slot(int'(held))] = val;
          held++;
        end
      end
      bdq_pkg::CMD_POP_BACK: begin
        if (held == '0) res.status = bdq_pkg::ST_EMPTY;
        else begin
          held--;
          res.data = ring[ring_slot(int'(held))];
        end
      end
      bdq_pkg::CMD_SHIFT_FRONT: begin
        if (held == '0) res.status = bdq_pkg::ST_EMPTY;
        else begin
          res.data = ring[front_slot];
          front_slot = ring_slot(1);
          held--;
        end
      end
      bdq_pkg::CMD_UNSHIFT_FRONT: begin
        if (int'(held) == bdq_pkg::DEPTH) res.status = bdq_pkg::ST_FULL;
        else begin
          front_slot = ring_slot(bdq_pkg::DEPTH - 1);
          ring[front_slot] = val;
          held++;
        end
      end
      bdq_pkg::CMD_REMOVE: begin
        // first match counted from the front, later words move up one place
        for (int i = 0; i < int'(held); i++)
          if (hit < 0 && ring[ring_slot(i)] == val) hit = i;
        if (hit < 0) res.status = bdq_pkg::ST_NOT_FOUND;
        else begin
          res.data = ring[ring_slot(hit)];
          for (int i = hit; i + 1 < int'(held); i++)
            ring[ring_slot(i)] = ring[ring_slot(i + 1)];
          held--;
        end
      end
      bdq_pkg::CMD_GET: begin
        if (int'(pos) >= int'(held)) res.status = bdq_pkg::ST_RANGE;
        else res.data = ring[ring_slot(int'(pos))];
      end
      default: ;
    endcase
    res.occ = held;
    pending_results.push_back(res);
  endtask

  // one input transfer; valid stays up after it, so the next command can follow with no gap
  task automatic send_command(input logic [2:0] cmd, input logic [bdq_pkg::DATA_W-1:0] val,
                              input logic [bdq_pkg::POS_W-1:0] pos);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {4'b0000, pos, val};
    s_axis_tuser_i  <= cmd;
    // inputs settle by the falling edge, so the handshake seen there holds at the next rise
    do @(negedge clk_i); while (!s_axis_tready_o);
    @(posedge clk_i);
    apply_command(cmd, val, pos);
  endtask

  // hold off the sender until every queued result has come back
  task automatic wait_results_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // small pool half the time so that duplicates and remove hits are common
  function automatic logic [bdq_pkg::DATA_W-1:0] pick_word();
    if ($urandom_range(1)) return bdq_pkg::DATA_W'($urandom_range(7));
    return $urandom();
  endfunction

  task automatic test_directed_edges();
    send_command(bdq_pkg::CMD_GET, 32'h0000_0000, 4'd0);          // get on empty queue
    send_command(bdq_pkg::CMD_POP_BACK, 32'h0000_0000, 4'd0);     // pop on empty queue
    send_command(bdq_pkg::CMD_SHIFT_FRONT, 32'h0000_0000, 4'd0);  // shift on empty queue
    send_command(bdq_pkg::CMD_REMOVE, 32'h0000_0000, 4'd0);       // remove on empty queue
    send_command(bdq_pkg::CMD_PUSH_BACK, 32'hFFFF_FFFF, 4'd15);
    send_command(bdq_pkg::CMD_UNSHIFT_FRONT, 32'h0000_0000, 4'd9);
    send_command(bdq_pkg::CMD_PUSH_BACK, 32'hA5A5_5A5A, 4'd0);
    send_command(bdq_pkg::CMD_GET, 32'hFFFF_FFFF, 4'd0);
    send_command(bdq_pkg::CMD_GET, 32'h0000_0000, 4'd2);
    send_command(bdq_pkg::CMD_GET, 32'h0000_0000, 4'd15);         // index past the end
    send_command(bdq_pkg::CMD_REMOVE, 32'h1234_5678, 4'd0);       // no match
    send_command(bdq_pkg::CMD_PUSH_BACK, 32'hFFFF_FFFF, 4'd0);
    send_command(bdq_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 4'd0);       // first of two matches goes
    send_command(bdq_pkg::CMD_GET, 32'h0000_0000, 4'd1);
    send_command(CMD_UNUSED_A, 32'hDEAD_BEEF, 4'd5);
    send_command(CMD_UNUSED_B, 32'hFFFF_FFFF, 4'd15);
    send_command(bdq_pkg::CMD_SHIFT_FRONT, 32'h0000_0000, 4'd0);
    send_command(bdq_pkg::CMD_POP_BACK, 32'h0000_0000, 4'd0);
    send_command(bdq_pkg::CMD_POP_BACK, 32'h0000_0000, 4'd0);
    send_command(bdq_pkg::CMD_POP_BACK, 32'h0000_0000, 4'd0);
  endtask

  // fill from both ends, overflow, get and remove at depth, then drain and underflow
  task automatic test_full_boundary();
    while (int'(held) != bdq_pkg::DEPTH)
      send_command($urandom_range(1) ? bdq_pkg::CMD_PUSH_BACK : bdq_pkg::CMD_UNSHIFT_FRONT,
                   pick_word(), bdq_pkg::POS_W'($urandom()));
    send_command(bdq_pkg::CMD_PUSH_BACK, $urandom(), 4'd0);
    send_command(bdq_pkg::CMD_UNSHIFT_FRONT, $urandom(), 4'd0);
    send_command(bdq_pkg::CMD_GET, 32'h0000_0000, 4'd15);
    // value taken from the very back
    send_command(bdq_pkg::CMD_REMOVE, ring[ring_slot(bdq_pkg::DEPTH - 1)], 4'd0);
    send_command(bdq_pkg::CMD_PUSH_BACK, $urandom(), 4'd0);
    send_command(bdq_pkg::CMD_REMOVE, ring[ring_slot(bdq_pkg::DEPTH / 2)], 4'd0);
    while (held != '0)
      send_command($urandom_range(1) ? bdq_pkg::CMD_POP_BACK : bdq_pkg::CMD_SHIFT_FRONT,
                   $urandom(), 4'd0);
    send_command(bdq_pkg::CMD_SHIFT_FRONT, 32'h0000_0000, 4'd0);
  endtask

  // random traffic in runs that lean towards filling or towards draining
  task automatic test_random_traffic(input int n_items);
    int grow;
    int roll;
    logic [2:0] cmd;
    logic [bdq_pkg::DATA_W-1:0] val;
    logic [bdq_pkg::POS_W-1:0] pos;
    grow = 45;
    for (int n = 0; n < n_items; n++) begin
      if (n % 40 == 0) grow = $urandom_range(1) ? 45 : 15;
      roll = $urandom_range(99);
      val = pick_word();
      pos = bdq_pkg::POS_W'($urandom());
      if (roll < 3) cmd = $urandom_range(1) ? CMD_UNUSED_A : CMD_UNUSED_B;
      else if (roll < 3 + grow)
        cmd = $urandom_range(1) ? bdq_pkg::CMD_PUSH_BACK : bdq_pkg::CMD_UNSHIFT_FRONT;
      else if (roll < 63)
        cmd = $urandom_range(1) ? bdq_pkg::CMD_POP_BACK : bdq_pkg::CMD_SHIFT_FRONT;
      else if (roll < 82) begin
        cmd = bdq_pkg::CMD_REMOVE;
        if (held != '0 && $urandom_range(99) < 70)
          val = ring[ring_slot(int'($urandom_range(int'(held) - 1)))];
      end else begin
        cmd = bdq_pkg::CMD_GET;
        if (held != '0 && $urandom_range(99) < 70)
          pos = bdq_pkg::POS_W'($urandom_range(int'(held) - 1));
      end
      send_command(cmd, val, pos);
    end
  endtask

  // receiver stalls, drawn again every cycle
  always @(posedge clk_i) begin
    m_axis_tready_i <= rst_ni && ($urandom_range(99) >= sink_idle_pct);
  end

  // result check and watchdog, sampled at the falling edge where everything is settled
  always @(negedge clk_i) begin
    deque_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("unexpected result: data %h status %0d occupancy %0d",
                   m_axis_tdata_o[31:0], m_axis_tuser_o, m_axis_tdata_o[36:32]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata_o[31:0] !== want.data || m_axis_tuser_o !== want.status ||
            m_axis_tdata_o[36:32] !== want.occ) begin
          if (error_count < MAX_REPORTS)
            $display("mismatch: data %h/%h status %0d/%0d occupancy %0d/%0d (exp/act)",
                     want.data, m_axis_tdata_o[31:0], want.status, m_axis_tuser_o,
                     want.occ, m_axis_tdata_o[36:32]);
          error_count++;
        end
      end
    end
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < bdq_pkg::DEPTH; i++) ring[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender mostly busy, receiver mostly stalling
    src_idle_pct  = 10;
    sink_idle_pct = 86;
    test_directed_edges();
    test_random_traffic(360);
    wait_results_drained();

    // sender mostly idle, receiver mostly ready
    src_idle_pct  = 86;
    sink_idle_pct = 10;
    test_full_boundary();
    test_random_traffic(340);
    wait_results_drained();

    // full rate both sides
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_full_boundary();
    test_random_traffic(340);

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/bdq_pkg.sv
rtl/bdq_dpath.sv
rtl/bdq_ctrl.sv
rtl/bounded_deque_with_remove.sv
bench/tb_bounded_deque_with_remove.sv
